// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define VS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define VS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/vsds_pkg.sv =====
// package: constants, codes and state type of the variation store delta unit
package vsds_pkg;
  localparam int STORE_BYTES     = 4096;
  localparam int MAX_AXES        = 4;
  localparam int MAX_REGION_REFS = 64;

  localparam int AW    = $clog2(STORE_BYTES);
  localparam int AXW   = $clog2(MAX_AXES + 1);
  localparam int REFW  = $clog2(MAX_REGION_REFS + 1);
  localparam int MW    = (AW + 1 > 18) ? AW + 1 : 18;
  localparam int SUM_W = 39;

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_EVAL  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_FMT   = 2'd1;
  localparam logic [1:0] ST_BAD_OUTER = 2'd2;
  localparam logic [1:0] ST_BAD_INNER = 2'd3;

  localparam logic [2:0] CFG_AXIS_COUNT = 3'd0;
  localparam logic [2:0] CFG_COORD0     = 3'd1;
  localparam logic [2:0] CFG_COORD1     = 3'd2;
  localparam logic [2:0] CFG_COORD2     = 3'd3;
  localparam logic [2:0] CFG_COORD3     = 3'd4;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [4:0] {
    S_IDLE, S_FETCH_A, S_FETCH_D,
    S_HDR_FMT, S_HDR_RL, S_HDR_DC, S_RL_AX, S_RL_RC,
    S_DS_PTR, S_DS_IC, S_DS_SC, S_DS_RC, S_MUL_ROW, S_ROW,
    S_REF_LOOP, S_REF_IDX, S_REF_DELTA, S_MUL_REG, S_REG_BASE,
    S_AX_LOOP, S_AX_EVAL, S_DIV, S_MUL_SC, S_SC_UPD,
    S_MUL_DELTA, S_ACC, S_DONE
  } state_e;
endpackage

// ===== hdl/vsds_ram.sv =====
// generic single write, single read ram with registered read data
module vsds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/variation_store_delta_sum.sv =====
// top level: iterative evaluator of one item variation store delta sum
// operation: a write item is stored in the cycle it is taken; an evaluate item reads the header,
// then per region reference its index and its delta (one byte or two), then per tent axis that
// divides six bytes and a 16-step divider, and wraps up with the result
// throughput: one item at a time; stall stays high until the result is registered
// reset: asynchronous active low, clears control, config and output valid; store undefined
module variation_store_delta_sum import vsds_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_addr_i,
  input  logic [15:0]             cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    cmd_i,
  input  logic [11:0]             byte_addr_i,
  input  logic [7:0]              byte_data_i,
  input  logic [15:0]             outer_index_i,
  input  logic [15:0]             inner_index_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SUM_W-1:0] delta_sum_o,
  output logic [1:0]              status_o
);
  // configuration
  logic [2:0]         axis_count_q;
  logic signed [15:0] coord_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_count_q <= '0;
      for (int k = 0; k < 4; k++) coord_q[k] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_AXIS_COUNT: axis_count_q <= cfg_wdata_i[2:0];
        CFG_COORD0:     coord_q[0]   <= cfg_wdata_i;
        CFG_COORD1:     coord_q[1]   <= cfg_wdata_i;
        CFG_COORD2:     coord_q[2]   <= cfg_wdata_i;
        CFG_COORD3:     coord_q[3]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer state and datapath registers
  state_e state_q, state_d, ret_q, ret_d;
  logic [2:0]  cnt_q, cnt_d;           // bytes left in the current fetch
  logic [AW-1:0] ptr_q, ptr_d;         // byte pointer of the fetch
  logic [47:0] acc_q, acc_d;           // fetched bytes, big-endian
  logic [15:0] outer_q, outer_d, inner_q, inner_d;
  logic [AW-1:0] rlist_q, rlist_d, dset_q, dset_d, idx_ptr_q, idx_ptr_d, dptr_q, dptr_d;
  logic [15:0] axes_q, axes_d, regions_q, regions_d;
  logic [15:0] items_q, items_d, short_q, short_d, refs_q, refs_d, ridx_q, ridx_d;
  logic [REFW-1:0] i_q, i_d, limit_q, limit_d;
  logic [AXW-1:0] a_q, a_d;
  logic signed [15:0] delta_q, delta_d;
  logic [16:0] scalar_q, scalar_d;
  logic [16:0] rem_q, rem_d, den_q, den_d;
  logic [15:0] quo_q, quo_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [1:0]  stat_q, stat_d;
  logic        out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] out_sum_q, out_sum_d;
  logic [1:0]  out_stat_q, out_stat_d;

  // shared multiplier, result registered every cycle
  logic [MW-1:0] mul_a, mul_b;
  logic signed [2*MW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(mul_a) * $signed(mul_b);
  end

  // store memory
  logic          ram_we;
  logic [7:0]    ram_rdata;

  vsds_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(byte_addr_i)),
    .wdata_i (byte_data_i),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // helpers
  logic [AXW-1:0] used_axes;
  logic [AW-1:0]  stride;
  logic signed [15:0] s_v, p_v, e_v, c_v;
  logic signed [16:0] c_s, p_s, e_c, e_p;
  logic [17:0] rem2;
  logic        in_short;

  assign used_axes = (32'(axis_count_q) < MAX_AXES) ? AXW'(axis_count_q) : AXW'(MAX_AXES);
  assign stride    = AW'({axes_q, 2'b00}) + AW'({axes_q, 1'b0});
  assign s_v = acc_q[47:32];
  assign p_v = acc_q[31:16];
  assign e_v = acc_q[15:0];
  assign c_v = (32'(a_q) < 4) ? coord_q[a_q[1:0]] : 16'sd0;
  assign c_s = 17'(c_v) - 17'(s_v);
  assign p_s = 17'(p_v) - 17'(s_v);
  assign e_c = 17'(e_v) - 17'(c_v);
  assign e_p = 17'(e_v) - 17'(p_v);
  assign rem2 = {rem_q, 1'b0};
  assign in_short = (16'(i_q) < short_q);

  always_comb begin
    state_d = state_q;  ret_d = ret_q;    cnt_d = cnt_q;     ptr_d = ptr_q;
    acc_d = acc_q;      outer_d = outer_q; inner_d = inner_q;
    rlist_d = rlist_q;  dset_d = dset_q;  idx_ptr_d = idx_ptr_q; dptr_d = dptr_q;
    axes_d = axes_q;    regions_d = regions_q; items_d = items_q;
    short_d = short_q;  refs_d = refs_q;  ridx_d = ridx_q;
    i_d = i_q;          limit_d = limit_q; a_d = a_q;        delta_d = delta_q;
    scalar_d = scalar_q; rem_d = rem_q;   den_d = den_q;     quo_d = quo_q;
    dcnt_d = dcnt_q;    sum_d = sum_q;    stat_d = stat_q;
    out_valid_d = out_valid_q; out_sum_d = out_sum_q; out_stat_d = out_stat_q;
    ram_we = 1'b0;
    mul_a = '0;
    mul_b = '0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_WRITE) begin
            ram_we = 1'b1;
          end else begin
            outer_d = outer_index_i;
            inner_d = inner_index_i;
            sum_d   = '0;
            stat_d  = ST_OK;
            ptr_d   = '0;
            cnt_d   = 3'd2;
            ret_d   = S_HDR_FMT;
            state_d = S_FETCH_A;
          end
        end
      end
      S_FETCH_A: state_d = S_FETCH_D;
      S_FETCH_D: begin
        acc_d = {acc_q[39:0], ram_rdata};
        ptr_d = ptr_q + 1'b1;
        cnt_d = cnt_q - 1'b1;
        state_d = (cnt_q == 3'd1) ? ret_q : S_FETCH_A;
      end
      S_HDR_FMT: begin
        if (acc_q[15:0] != 16'd1) begin
          stat_d = ST_BAD_FMT;
          state_d = S_DONE;
        end else begin
          cnt_d = 3'd4; ret_d = S_HDR_RL; state_d = S_FETCH_A;
        end
      end
      S_HDR_RL: begin
        rlist_d = AW'(acc_q[31:0]);
        cnt_d = 3'd2; ret_d = S_HDR_DC; state_d = S_FETCH_A;
      end
      S_HDR_DC: begin
        if (outer_q >= acc_q[15:0]) begin
          stat_d = ST_BAD_OUTER;
          state_d = S_DONE;
        end else begin
          ptr_d = rlist_q; cnt_d = 3'd2; ret_d = S_RL_AX; state_d = S_FETCH_A;
        end
      end
      S_RL_AX: begin
        axes_d = acc_q[15:0];
        cnt_d = 3'd2; ret_d = S_RL_RC; state_d = S_FETCH_A;
      end
      S_RL_RC: begin
        regions_d = acc_q[15:0];
        ptr_d = AW'(8) + AW'({outer_q, 2'b00});
        cnt_d = 3'd4; ret_d = S_DS_PTR; state_d = S_FETCH_A;
      end
      S_DS_PTR: begin
        dset_d = AW'(acc_q[31:0]);
        ptr_d = AW'(acc_q[31:0]);
        cnt_d = 3'd2; ret_d = S_DS_IC; state_d = S_FETCH_A;
      end
      S_DS_IC: begin
        items_d = acc_q[15:0];
        cnt_d = 3'd2; ret_d = S_DS_SC; state_d = S_FETCH_A;
      end
      S_DS_SC: begin
        short_d = acc_q[15:0];
        cnt_d = 3'd2; ret_d = S_DS_RC; state_d = S_FETCH_A;
      end
      S_DS_RC: begin
        refs_d = acc_q[15:0];
        if (inner_q >= items_q) begin
          stat_d = ST_BAD_INNER;
          state_d = S_DONE;
        end else begin
          idx_ptr_d = dset_q + AW'(6);
          limit_d = (32'(acc_q[15:0]) < MAX_REGION_REFS) ? REFW'(acc_q[15:0])
                                                          : REFW'(MAX_REGION_REFS);
          state_d = S_MUL_ROW;
        end
      end
      S_MUL_ROW: begin
        mul_a = MW'(inner_q);
        mul_b = MW'(17'(short_q) + 17'(refs_q));
        state_d = S_ROW;
      end
      S_ROW: begin
        dptr_d = idx_ptr_q + AW'({refs_q, 1'b0}) + prod_q[AW-1:0];
        i_d = '0;
        state_d = S_REF_LOOP;
      end
      S_REF_LOOP: begin
        if (i_q == limit_q) begin
          state_d = S_DONE;
        end else begin
          ptr_d = idx_ptr_q; cnt_d = 3'd2; ret_d = S_REF_IDX; state_d = S_FETCH_A;
        end
      end
      S_REF_IDX: begin
        ridx_d = acc_q[15:0];
        idx_ptr_d = ptr_q;
        ptr_d = dptr_q;
        cnt_d = in_short ? 3'd2 : 3'd1;
        ret_d = S_REF_DELTA;
        state_d = S_FETCH_A;
      end
      S_REF_DELTA: begin
        delta_d = in_short ? $signed(acc_q[15:0]) : 16'(signed'(acc_q[7:0]));
        dptr_d = ptr_q;
        if (ridx_q >= regions_q) begin
          i_d = i_q + 1'b1;
          state_d = S_REF_LOOP;
        end else begin
          state_d = S_MUL_REG;
        end
      end
      S_MUL_REG: begin
        mul_a = MW'(ridx_q);
        mul_b = MW'(stride);
        state_d = S_REG_BASE;
      end
      S_REG_BASE: begin
        ptr_d = rlist_q + AW'(4) + prod_q[AW-1:0];
        scalar_d = ONE_Q16;
        a_d = '0;
        state_d = S_AX_LOOP;
      end
      S_AX_LOOP: begin
        if (16'(a_q) == axes_q) begin
          state_d = S_MUL_DELTA;
        end else if (a_q >= used_axes) begin
          scalar_d = '0;
          state_d = S_MUL_DELTA;
        end else begin
          cnt_d = 3'd6; ret_d = S_AX_EVAL; state_d = S_FETCH_A;
        end
      end
      S_AX_EVAL: begin
        priority if (s_v > p_v || p_v > e_v || p_v == 16'sd0 || c_v == p_v) begin
          a_d = a_q + 1'b1;
          state_d = S_AX_LOOP;
        end else if (c_v <= s_v || c_v >= e_v) begin
          scalar_d = '0;
          state_d = S_MUL_DELTA;
        end else begin
          rem_d = (c_v < p_v) ? c_s : e_c;
          den_d = (c_v < p_v) ? p_s : e_p;
          quo_d = '0;
          dcnt_d = 5'd16;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle, remainder stays below the divisor
        if (rem2 >= {1'b0, den_q}) begin
          rem_d = 17'(rem2 - {1'b0, den_q});
          quo_d = {quo_q[14:0], 1'b1};
        end else begin
          rem_d = rem2[16:0];
          quo_d = {quo_q[14:0], 1'b0};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 5'd1) state_d = S_MUL_SC;
      end
      S_MUL_SC: begin
        mul_a = MW'(scalar_q);
        mul_b = MW'(quo_q);
        state_d = S_SC_UPD;
      end
      S_SC_UPD: begin
        scalar_d = prod_q[32:16];
        a_d = a_q + 1'b1;
        state_d = S_AX_LOOP;
      end
      S_MUL_DELTA: begin
        mul_a = MW'(scalar_q);
        mul_b = MW'(delta_q);
        state_d = S_ACC;
      end
      S_ACC: begin
        sum_d = sum_q + SUM_W'(prod_q);
        i_d = i_q + 1'b1;
        state_d = S_REF_LOOP;
      end
      S_DONE: begin
        // wait for the output register to be free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_sum_d   = (stat_q == ST_OK) ? sum_q : '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;       acc_q <= acc_d;       outer_q <= outer_d;   inner_q <= inner_d;
    rlist_q <= rlist_d;   dset_q <= dset_d;     idx_ptr_q <= idx_ptr_d; dptr_q <= dptr_d;
    axes_q <= axes_d;     regions_q <= regions_d; items_q <= items_d; short_q <= short_d;
    refs_q <= refs_d;     ridx_q <= ridx_d;     i_q <= i_d;           limit_q <= limit_d;
    a_q <= a_d;           delta_q <= delta_d;   scalar_q <= scalar_d; rem_q <= rem_d;
    den_q <= den_d;       quo_q <= quo_d;       sum_q <= sum_d;       stat_q <= stat_d;
    out_sum_q <= out_sum_d; out_stat_q <= out_stat_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign delta_sum_o = out_sum_q;
  assign status_o    = out_stat_q;
endmodule

// ===== hdl/vsds_checker.sv =====
// port-level checker for the variation store delta unit, bound to the top level
`include "assert_macros.svh"
module vsds_checker import vsds_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    cmd_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [SUM_W-1:0] delta_sum_o,
  input logic [1:0]              status_o
);
  `VS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(delta_sum_o) && $stable(status_o), "stalled result changed")
  `VS_ASSERT(a_err_zero, out_valid_o && status_o != ST_OK, delta_sum_o == '0, "error result has nonzero sum")
  `VS_ASSERT_NEXT(a_write_quiet, in_valid_i && !in_stall_o && cmd_i == CMD_WRITE, !$rose(out_valid_o), "write item produced a result")
  `VS_ASSERT_NEXT(a_eval_busy, in_valid_i && !in_stall_o && cmd_i == CMD_EVAL, in_stall_o, "evaluate item did not stall input")
endmodule

bind variation_store_delta_sum vsds_checker u_vsds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .delta_sum_o (delta_sum_o),
  .status_o    (status_o)
);

// ===== dv/tb_variation_store_delta_sum.sv =====
// testbench for the variation store delta sum unit: random stores, evaluations and config
module tb_variation_store_delta_sum;
  import vsds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 80;       // evaluation latency margin before config writes
  localparam int CYCLE_LIMIT   = 4000000;  // slowest plausible run, several times over

  typedef struct {
    logic        cmd;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] outer;
    logic [15:0] inner;
  } store_item_t;

  typedef struct {
    logic [SUM_W-1:0] sum;
    logic [1:0]       status;
  } delta_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // dut inputs, all known from time zero
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = CFG_AXIS_COUNT;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        cmd = CMD_WRITE;
  logic [11:0] byte_addr = '0;
  logic [7:0]  byte_data = '0;
  logic [15:0] outer_index = '0;
  logic [15:0] inner_index = '0;
  logic        out_stall = 1'b0;

  logic                    in_stall;
  logic                    out_valid;
  logic signed [SUM_W-1:0] delta_sum;
  logic [1:0]              status;

  variation_store_delta_sum dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .byte_addr_i   (byte_addr),
    .byte_data_i   (byte_data),
    .outer_index_i (outer_index),
    .inner_index_i (inner_index),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .delta_sum_o   (delta_sum),
    .status_o      (status)
  );

  always #1 clk_i = ~clk_i;

  // items waiting for the driver and results waiting for the monitor
  store_item_t   pending_items[$];
  delta_result_t expected_sums[$];
  int            fails = 0;
  bit            calm = 1'b0;   // phase without any idling on either side

  // shadow of the store and the registers, as seen after all queued items
  logic [7:0] shadow_mem[STORE_BYTES];
  bit         written[STORE_BYTES];
  int         unwritten_reads[$];
  int         axis_cnt = 0;
  int         coord[4] = '{0, 0, 0, 0};

  // shape of the last store built, used to aim evaluations at valid rows
  int cur_dc = 1;
  int cur_ic[3] = '{1, 1, 1};

  // most gaps short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // ---------------------------------------------------------------- store shadow reads
  // every read address is taken modulo the store size; unwritten bytes are logged
  function automatic logic [7:0] peek8(longint unsigned a);
    int idx;
    idx = int'(a % STORE_BYTES);
    if (!written[idx]) unwritten_reads.push_back(idx);
    return shadow_mem[idx];
  endfunction

  function automatic logic [15:0] peek16(longint unsigned a);
    return {peek8(a), peek8(a + 1)};
  endfunction

  function automatic logic [31:0] peek32(longint unsigned a);
    return {peek16(a), peek16(a + 2)};
  endfunction

  // product of tent ratios over the store axes, unsigned q16, truncated each step
  function automatic logic [31:0] tent_product(longint unsigned base_a, int store_axes,
                                               int used_axes);
    int s, p, e, c;
    logic [31:0] scalar, ratio;
    longint unsigned prod;
    scalar = 32'(ONE_Q16);
    for (int a = 0; a < store_axes; a++) begin
      if (a >= used_axes) return '0;   // axis with no coordinate kills the region
      s = $signed(peek16(base_a + a * 6));
      p = $signed(peek16(base_a + a * 6 + 2));
      e = $signed(peek16(base_a + a * 6 + 4));
      c = (a < 4) ? coord[a] : 0;
      if (s > p || p > e) continue;   // malformed tent is neutral
      if (p == 0 || c == p) continue;
      if (c <= s || c >= e) return '0;
      if (c < p) ratio = 32'(((longint'(c - s)) << 16) / longint'(p - s));
      else ratio = 32'(((longint'(e - c)) << 16) / longint'(e - p));
      prod = longint'(scalar) * longint'(ratio);
      scalar = 32'(prod >> 16);
    end
    return scalar;
  endfunction

  // full evaluation of one delta against the shadow store
  function automatic delta_result_t delta_eval(logic [15:0] outer, logic [15:0] inner);
    delta_result_t res;
    longint unsigned rlist, dset, idx_base, row, row_bytes;
    int n_sets, store_axes, n_regions, n_rows, short_count, ref_count;
    int used_axes, limit, ridx, delta;
    logic [31:0] sc;
    longint sum;
    sum = 0;
    res.status = ST_OK;
    if (peek16(0) != 16'd1) begin
      res.status = ST_BAD_FMT;
    end else begin
      rlist = peek32(2);
      n_sets = peek16(6);
      if (outer >= n_sets) begin
        res.status = ST_BAD_OUTER;
      end else begin
        store_axes = peek16(rlist);
        n_regions = peek16(rlist + 2);
        dset = peek32(8 + longint'(outer) * 4);
        n_rows = peek16(dset);
        short_count = peek16(dset + 2);
        ref_count = peek16(dset + 4);
        if (inner >= n_rows) begin
          res.status = ST_BAD_INNER;
        end else begin
          used_axes = (axis_cnt < MAX_AXES) ? axis_cnt : MAX_AXES;
          idx_base = dset + 6;
          row_bytes = longint'(short_count) + ref_count;
          row = idx_base + longint'(ref_count) * 2 + longint'(inner) * row_bytes;
          limit = (ref_count < MAX_REGION_REFS) ? ref_count : MAX_REGION_REFS;
          for (int i = 0; i < limit; i++) begin
            ridx = peek16(idx_base + i * 2);
            if (i < short_count) delta = $signed(peek16(row + i * 2));
            else delta = $signed(peek8(row + longint'(short_count) * 2 + (i - short_count)));
            if (ridx >= n_regions) continue;
            sc = tent_product(rlist + 4 + longint'(ridx) * (longint'(store_axes) * 6),
                              store_axes, used_axes);
            sum += longint'(sc) * longint'(delta);
          end
        end
      end
    end
    res.sum = (res.status == ST_OK) ? sum[SUM_W-1:0] : '0;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus building
  function automatic void put8(longint unsigned a, logic [7:0] v);
    store_item_t it;
    it.cmd = CMD_WRITE;
    it.addr = 12'(a % STORE_BYTES);
    it.data = v;
    it.outer = 16'($urandom);
    it.inner = 16'($urandom);
    pending_items.push_back(it);
    shadow_mem[it.addr] = v;
    written[it.addr] = 1'b1;
  endfunction

  function automatic void put16(longint unsigned a, logic [15:0] v);
    put8(a, v[15:8]);
    put8(a + 1, v[7:0]);
  endfunction

  function automatic void put32(longint unsigned a, logic [31:0] v);
    put16(a, v[31:16]);
    put16(a + 2, v[15:0]);
  endfunction

  // delta bytes lean toward the sign boundaries
  function automatic logic [7:0] delta_byte();
    case ($urandom_range(5))
      0: return 8'h7f;
      1: return 8'h80;
      2: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // evaluation item: bytes it would read unwritten get written first
  function automatic void queue_eval(logic [15:0] outer, logic [15:0] inner);
    store_item_t it;
    delta_result_t res;
    forever begin
      unwritten_reads.delete();
      res = delta_eval(outer, inner);
      if (unwritten_reads.size() == 0) break;
      foreach (unwritten_reads[k])
        if (!written[unwritten_reads[k]]) put8(unwritten_reads[k], 8'($urandom));
    end
    it.cmd = CMD_EVAL;
    it.addr = 12'($urandom);
    it.data = 8'($urandom);
    it.outer = outer;
    it.inner = inner;
    pending_items.push_back(it);
    expected_sums.push_back(res);
  endfunction

  // one axis record of a region: start, peak, end
  function automatic void put_tent(longint unsigned a, int axis);
    int s, p, e, r, t;
    r = $urandom_range(99);
    p = $urandom_range(32768) - 16384;
    if (r < 10 && axis < 4) p = coord[axis];   // coordinate right on the peak
    if (r >= 70 && r < 80) p = 0;
    s = $urandom_range(p + 16384) - 16384;
    e = p + $urandom_range(16384 - p);
    if (r >= 80 && r < 88) begin               // start above peak
      t = s; s = e; e = t;
    end
    if (r >= 88) begin
      s = $signed(16'($urandom));
      p = $signed(16'($urandom));
      e = $signed(16'($urandom));
    end
    put16(a, s[15:0]);
    put16(a + 2, p[15:0]);
    put16(a + 4, e[15:0]);
  endfunction

  // a well-formed store with random content at random places
  function automatic void build_store(bit extreme);
    int r_base, nax, rc, cursor, nref, sh;
    logic [31:0] hi;
    cur_dc = $urandom_range(3, 1);
    case ($urandom_range(9))
      0: nax = 0;
      1: nax = 5;
      default: nax = $urandom_range(4, 1);
    endcase
    if (extreme) nax = 5;
    rc = $urandom_range(3, 1);
    r_base = $urandom_range(3800, 64);
    hi = $urandom & 32'hffff_f000;   // upper pointer bits are dropped by the wrap
    put16(0, 16'd1);
    put32(2, hi | r_base);
    put16(6, 16'(cur_dc));
    put16(r_base, 16'(nax));
    put16(r_base + 2, 16'(rc));
    for (int g = 0; g < rc; g++)
      for (int a = 0; a < nax; a++) put_tent(r_base + 4 + (g * nax + a) * 6, a);
    cursor = r_base + 4 + rc * nax * 6 + $urandom_range(8);
    for (int o = 0; o < cur_dc; o++) begin
      hi = $urandom & 32'hffff_f000;
      put32(8 + o * 4, hi | (cursor % STORE_BYTES));
      cur_ic[o] = $urandom_range(3, 1);
      if (extreme && o == 0) nref = 66;            // more refs than are summed
      else if ($urandom_range(19) == 0) nref = $urandom_range(12, 6);
      else nref = $urandom_range(5);
      sh = ($urandom_range(9) == 0) ? $urandom_range(nref + 2) : $urandom_range(nref);
      if (extreme && o == 0) sh = 2;
      put16(cursor, 16'(cur_ic[o]));
      put16(cursor + 2, 16'(sh));
      put16(cursor + 4, 16'(nref));
      for (int i = 0; i < nref; i++)
        put16(cursor + 6 + i * 2,
              16'(($urandom_range(99) < 85) ? $urandom_range(rc - 1) : $urandom_range(65535)));
      for (int b = 0; b < cur_ic[o] * (sh + nref); b++)
        put8(cursor + 6 + nref * 2 + b, delta_byte());
      cursor += 6 + nref * 2 + cur_ic[o] * (sh + nref) + $urandom_range(8);
    end
  endfunction

  // ---------------------------------------------------------------- driver
  logic in_taken = 1'b0;
  int   in_gap = 0;
  int   stall_left = 0;

  always @(posedge clk_i) in_taken <= in_valid && !in_stall;

  always @(negedge clk_i) begin
    store_item_t it;
    if (rst_ni && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        cmd <= it.cmd;
        byte_addr <= it.addr;
        byte_data <= it.data;
        outer_index <= it.outer;
        inner_index <= it.inner;
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    delta_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $error("result with no evaluation pending: delta_sum %0d status %0d",
               delta_sum, status);
        fails++;
      end else begin
        want = expected_sums.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fails++;
        end
        if (delta_sum !== want.sum) begin
          $error("delta_sum: expected %0d, got %0d", $signed(want.sum), delta_sum);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("variation_store_delta_sum: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequencing
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_sums.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] v);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_AXIS_COUNT) axis_cnt = v[2:0];
    else coord[idx - CFG_COORD0] = $signed(v);
  endtask

  // coordinate for a phase: extremes or anything in range
  function automatic logic [15:0] pick_coord(bit edges);
    int v;
    if (edges) begin
      case ($urandom_range(4))
        0: v = -16384;
        1: v = 16384;
        2: v = 0;
        3: v = -1;
        default: v = 1;
      endcase
    end else begin
      v = $urandom_range(32768) - 16384;
    end
    return v[15:0];
  endfunction

  initial begin
    int axis_plan[8] = '{4, 7, 1, 0, 3, 5, 2, 4};
    int r;
    int o;
    for (int i = 0; i < STORE_BYTES; i++) begin
      shadow_mem[i] = '0;
      written[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values, empty store: the evaluation only sees the format word
    queue_eval(16'd0, 16'd0);
    wait_idle();

    // directed: extreme coordinates, a store with every corner in it
    cfg_write(CFG_AXIS_COUNT, 16'd2);
    cfg_write(CFG_COORD0, 16'd16384);
    cfg_write(CFG_COORD1, 16'hc000);
    cfg_write(CFG_COORD2, 16'd8192);
    cfg_write(CFG_COORD3, 16'hffff);
    build_store(1'b1);
    queue_eval(16'd0, 16'd0);
    queue_eval(16'(cur_dc - 1), 16'(cur_ic[cur_dc - 1] - 1));
    queue_eval(16'hffff, 16'd0);
    queue_eval(16'd0, 16'hffff);
    queue_eval(16'(cur_dc), 16'd0);
    queue_eval(16'd0, 16'(cur_ic[0]));
    put8(0, 8'h80);                 // format word broken
    queue_eval(16'd0, 16'd0);
    put8(0, 8'h00);
    queue_eval(16'd0, 16'(cur_ic[0] - 1));
    wait_idle();

    // random phases, each with its own register setting and store
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph % 3 == 2);
      cfg_write(CFG_AXIS_COUNT, 16'(axis_plan[ph]));
      cfg_write(CFG_COORD0, pick_coord(ph[0]));
      cfg_write(CFG_COORD1, pick_coord(ph[0]));
      cfg_write(CFG_COORD2, pick_coord(ph[0]));
      cfg_write(CFG_COORD3, pick_coord(ph[0]));
      build_store(1'b0);
      for (int n = 0; n < 50; n++) begin
        r = $urandom_range(99);
        if (r < 6) begin
          put8($urandom_range(4095), 8'($urandom));      // stray write
        end else if (r < 8) begin
          put8(1, 8'($urandom_range(255, 2)));           // format broken, then mended
          queue_eval(16'($urandom), 16'($urandom));
          put8(1, 8'h01);
        end else if (r < 10) begin
          build_store(1'b0);
        end else if (r < 16) begin
          queue_eval(16'($urandom), 16'($urandom));
        end else begin
          o = $urandom_range(cur_dc - 1);
          queue_eval(16'(o), 16'((r < 22) ? $urandom_range(65535)
                                           : $urandom_range(cur_ic[o] - 1)));
        end
      end
      wait_idle();
    end

    if (fails == 0) begin
      $display("variation_store_delta_sum: match");
    end else begin
      $display("variation_store_delta_sum: mismatch");
    end
    $finish;
  end
endmodule
